// ----- hw/rtl/imuco_pkg.sv -----
// imuco_pkg: widths, angle constants, register map and CORDIC arctangent table
// for the IMU complementary orientation filter. No dependencies.
package imuco_pkg;

  localparam int TS_W    = 32;
  localparam int RATE_W  = 24;
  localparam int ACCEL_W = 16;
  localparam int ANG_W   = 31;
  localparam int WGT_W   = 17;
  localparam int ACC_W   = 51;   // holds angle + rate*dt before reduction
  localparam int MA_W    = 25;   // multiplier port a: rate or weight
  localparam int MB_W    = 33;   // multiplier port b: dt or angle
  localparam int PROD_W  = MA_W + MB_W;
  localparam int CX_W    = 34;   // CORDIC x/y datapath
  localparam int CZ_W    = 32;   // CORDIC angle accumulator
  localparam int CNT_W   = 5;

  localparam int CORDIC_STEPS = 24;
  localparam int WRAP_TOP     = 19;  // 2*pi << 20 exceeds any pre-reduction value

  localparam longint ANG_PI      = 64'sd843314857;
  localparam longint ANG_2PI     = 64'sd1686629714;
  localparam longint ANG_HALF_PI = 64'sd421657428;

  localparam int APB_AW = 4;
  localparam logic [1:0] REG_GYRO_W  = 2'd0;
  localparam logic [1:0] REG_ACCEL_W = 2'd1;
  localparam logic [1:0] REG_BLEND   = 2'd2;

  localparam logic [WGT_W-1:0] GYRO_W_RST  = 17'd64225;
  localparam logic [WGT_W-1:0] ACCEL_W_RST = 17'd1311;

  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [CNT_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      5'd28: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/imuco_in_if.sv -----
// imuco_in_if: sample channel (timestamp, gyro rates, accelerations).
// Depends on imuco_pkg.
interface imuco_in_if import imuco_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic        [TS_W-1:0]      timestamp;
  logic signed [RATE_W-1:0]    rate_x;
  logic signed [RATE_W-1:0]    rate_y;
  logic signed [RATE_W-1:0]    rate_z;
  logic signed [ACCEL_W-1:0]   accel_x;
  logic signed [ACCEL_W-1:0]   accel_y;
  logic signed [ACCEL_W-1:0]   accel_z;

  modport source (output valid, timestamp, rate_x, rate_y, rate_z,
                  accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, timestamp, rate_x, rate_y, rate_z,
                  accel_x, accel_y, accel_z, output ready);
endinterface

// ----- hw/rtl/imuco_out_if.sv -----
// imuco_out_if: orientation result channel (roll, pitch, yaw).
// Depends on imuco_pkg.
interface imuco_out_if import imuco_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  roll_out;
  logic signed [ANG_W-1:0]  pitch_out;
  logic signed [ANG_W-1:0]  yaw_out;

  modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink   (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

// ----- hw/rtl/imu_complementary_orientation.sv -----
// imu_complementary_orientation: complementary roll/pitch/yaw filter top level.
// Depends on imuco_pkg, imuco_in_if, imuco_out_if.
//
// Usage:
//   in_if  : one IMU sample per beat (timestamp, three rates, three accels).
//   out_if : one beat per sample with roll, pitch and yaw, 2^-28 rad, [-pi,pi).
//   cfg_*  : APB write/read of gyro_weight (0x0), accel_weight (0x4),
//            blend_enable (0x8); write only while the block is idle.
// Timing: in_if.ready is high only while the sequencer is idle. A sample runs
//   per axis one multiply, one add and a modulo-2*pi reduction (one conditional
//   add or subtract of 2*pi<<k per cycle), then per blended angle 24 CORDIC
//   iterations, two multiplies on the same shared multiplier, a rounding add
//   and another reduction.
// The first sample after reset uses dt = 0. Reset clears angles, the previous
//   timestamp and the output valid flag, and restores the default weights.
// A finished result sits in the output register; if the receiver stalls, the
//   next sample is still accepted and computed, and holds in its final state
//   until the output register frees up.
module imu_complementary_orientation import imuco_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  imuco_in_if.sink          in_if,
  imuco_out_if.source       out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_WRAP  = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CITER = 4'd6;
  localparam logic [3:0] S_BM1   = 4'd7;
  localparam logic [3:0] S_BM2   = 4'd8;
  localparam logic [3:0] S_BM3   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [2:0] PH_ROLL   = 3'd0;
  localparam logic [2:0] PH_PITCH  = 3'd1;
  localparam logic [2:0] PH_YAW    = 3'd2;
  localparam logic [2:0] PH_BROLL  = 3'd3;
  localparam logic [2:0] PH_BPITCH = 3'd4;

  localparam acc_t TWO_PI_A = ACC_W'(ANG_2PI);
  localparam acc_t PI_A     = ACC_W'(ANG_PI);
  localparam logic signed [CZ_W-1:0] HALF_PI_Z = CZ_W'(ANG_HALF_PI);

  // configuration
  logic [WGT_W-1:0] gw_r, aw_r;
  logic             be_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GYRO_W_RST;
      aw_r <= ACCEL_W_RST;
      be_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_GYRO_W:  gw_r <= cfg_pwdata[WGT_W-1:0];
        REG_ACCEL_W: aw_r <= cfg_pwdata[WGT_W-1:0];
        REG_BLEND:   be_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_GYRO_W:  cfg_prdata = {{(32-WGT_W){1'b0}}, gw_r};
      REG_ACCEL_W: cfg_prdata = {{(32-WGT_W){1'b0}}, aw_r};
      REG_BLEND:   cfg_prdata = {31'b0, be_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  logic [3:0]       state_r;
  logic [2:0]       ph_r;
  logic [CNT_W-1:0] cnt_r;
  logic             seen_r;
  logic [TS_W-1:0]  prev_r, dt_r;
  angle_t           roll_r, pitch_r, yaw_r;
  logic signed [RATE_W-1:0]  rx_r, ry_r, rz_r;
  logic signed [ACCEL_W-1:0] ax_r, az_r;
  logic signed [ACCEL_W:0]   ay_r;   // may hold +32768 after the flip
  logic                      neg_r;
  logic signed [PROD_W-1:0]  prod_r;
  acc_t                      acc_r;
  logic signed [CX_W-1:0]    cx_r, cy_r;
  logic signed [CZ_W-1:0]    cz_r;
  logic                      ov_r;
  angle_t                    oroll_r, opitch_r, oyaw_r;

  logic in_acc, out_load;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_DONE) && (!ov_r || out_if.ready);

  assign out_if.valid     = ov_r;
  assign out_if.roll_out  = oroll_r;
  assign out_if.pitch_out = opitch_r;
  assign out_if.yaw_out   = oyaw_r;

  // shared multiplier operands
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;
  angle_t                   cur_ang;

  always_comb begin
    unique case (ph_r)
      PH_ROLL, PH_BROLL:   cur_ang = roll_r;
      PH_PITCH, PH_BPITCH: cur_ang = pitch_r;
      default:             cur_ang = yaw_r;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_MUL: begin
        unique case (ph_r)
          PH_ROLL:  ma = MA_W'(rx_r);
          PH_PITCH: ma = MA_W'(ry_r);
          default:  ma = MA_W'(rz_r);
        endcase
        mb = $signed({1'b0, dt_r});
      end
      S_BM1: begin
        ma = $signed({{(MA_W-WGT_W){1'b0}}, gw_r});
        mb = MB_W'(cur_ang);
      end
      S_BM2: begin
        ma = $signed({{(MA_W-WGT_W){1'b0}}, aw_r});
        mb = MB_W'(cz_r);
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // integration increment, rounded to 2^-28 rad
  logic signed [PROD_W-1:0] inc_rnd, inc;
  always_comb begin
    inc_rnd = (prod_r + PROD_W'(128)) >>> 8;
    inc = (neg_r && ph_r != PH_ROLL) ? -inc_rnd : inc_rnd;
  end

  // reduction step: one conditional add or subtract of 2*pi << k
  acc_t wrap_m, wrap_nxt, fix_nxt;
  always_comb begin
    wrap_m = TWO_PI_A << cnt_r;
    if (acc_r >= wrap_m)
      wrap_nxt = acc_r - wrap_m;
    else if (acc_r < -wrap_m)
      wrap_nxt = acc_r + wrap_m;
    else
      wrap_nxt = acc_r;
    if (acc_r < -PI_A)
      fix_nxt = acc_r + TWO_PI_A;
    else if (acc_r >= PI_A)
      fix_nxt = acc_r - TWO_PI_A;
    else
      fix_nxt = acc_r;
  end

  // blend rounding
  logic signed [PROD_W-1:0] bsum;
  assign bsum = (PROD_W'(acc_r) + prod_r + PROD_W'(32768)) >>> 16;

  // CORDIC init and iteration
  logic signed [CX_W-1:0] cin_y, cin_x, cxs, cys;
  assign cin_y = (ph_r == PH_BROLL) ? (CX_W'(ay_r) <<< 14) : (CX_W'(ax_r) <<< 14);
  assign cin_x = CX_W'(az_r) <<< 14;
  assign cxs = cx_r >>> cnt_r;
  assign cys = cy_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_ROLL;
      cnt_r   <= '0;
      seen_r  <= 1'b0;
      prev_r  <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (out_load)
        ov_r <= 1'b1;
      else if (out_if.ready)
        ov_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dt_r   <= seen_r ? (in_if.timestamp - prev_r) : '0;
            prev_r <= in_if.timestamp;
            seen_r <= 1'b1;
            rx_r   <= in_if.rate_x;
            ry_r   <= in_if.rate_y;
            rz_r   <= in_if.rate_z;
            ax_r   <= in_if.accel_x;
            az_r   <= in_if.accel_z;
            neg_r  <= in_if.accel_z[ACCEL_W-1];
            ay_r   <= in_if.accel_z[ACCEL_W-1] ? -(ACCEL_W+1)'(in_if.accel_y)
                                               :  (ACCEL_W+1)'(in_if.accel_y);
            ph_r    <= PH_ROLL;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_ADD;
        end
        S_ADD: begin
          acc_r   <= ACC_W'(cur_ang) + inc[ACC_W-1:0];
          cnt_r   <= CNT_W'(WRAP_TOP);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          acc_r <= wrap_nxt;
          if (cnt_r == '0)
            state_r <= S_FIX;
          else
            cnt_r <= cnt_r - 1'b1;
        end
        S_FIX: begin
          unique case (ph_r)
            PH_ROLL, PH_BROLL:   roll_r  <= fix_nxt[ANG_W-1:0];
            PH_PITCH, PH_BPITCH: pitch_r <= fix_nxt[ANG_W-1:0];
            default:             yaw_r   <= fix_nxt[ANG_W-1:0];
          endcase
          priority if (ph_r == PH_ROLL || ph_r == PH_PITCH) begin
            ph_r    <= ph_r + 1'b1;
            state_r <= S_MUL;
          end else if (ph_r == PH_YAW) begin
            if (be_r && az_r != '0) begin
              ph_r    <= PH_BROLL;
              state_r <= S_CINIT;
            end else begin
              state_r <= S_DONE;
            end
          end else if (ph_r == PH_BROLL) begin
            ph_r    <= PH_BPITCH;
            state_r <= S_CINIT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CINIT: begin
          if (az_r < 0) begin
            if (cin_y >= 0) begin
              cx_r <= cin_y;
              cy_r <= -cin_x;
              cz_r <= HALF_PI_Z;
            end else begin
              cx_r <= -cin_y;
              cy_r <= cin_x;
              cz_r <= -HALF_PI_Z;
            end
          end else begin
            cx_r <= cin_x;
            cy_r <= cin_y;
            cz_r <= '0;
          end
          cnt_r   <= '0;
          state_r <= S_CITER;
        end
        S_CITER: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + cys;
            cy_r <= cy_r - cxs;
            cz_r <= cz_r + atan_lut(cnt_r);
          end else begin
            cx_r <= cx_r - cys;
            cy_r <= cy_r + cxs;
            cz_r <= cz_r - atan_lut(cnt_r);
          end
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1))
            state_r <= S_BM1;
          else
            cnt_r <= cnt_r + 1'b1;
        end
        S_BM1: begin
          prod_r  <= prod;
          state_r <= S_BM2;
        end
        S_BM2: begin
          acc_r   <= prod_r[ACC_W-1:0];
          prod_r  <= prod;
          state_r <= S_BM3;
        end
        S_BM3: begin
          acc_r   <= bsum[ACC_W-1:0];
          cnt_r   <= CNT_W'(WRAP_TOP);
          state_r <= S_WRAP;
        end
        S_DONE: begin
          if (out_load)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      oroll_r  <= roll_r;
      opitch_r <= pitch_r;
      oyaw_r   <= yaw_r;
    end
  end

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accepting a beat");

  a_wrap_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRAP |-> cnt_r <= CNT_W'(WRAP_TOP))
    else $error("reduction counter out of range");

  a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |-> (fix_nxt >= -PI_A && fix_nxt < PI_A))
    else $error("reduced angle outside [-pi, pi)");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for imu_complementary_orientation. Sample beats come
// from a queue, orientation beats are checked against an in-bench predictor.
// Depends on imuco_pkg, imuco_in_if, imuco_out_if and the RTL top.
module tb import imuco_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TS_W-1:0]           timestamp;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_z;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } orient_t;

  localparam longint ATAN_ROM [32] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  imuco_in_if  in_if ();
  imuco_out_if out_if ();

  imu_complementary_orientation i_dut (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #10 clk = ~clk;

  // predictor state
  longint gyro_w, accel_w;
  bit     blend_on;
  longint roll_q, pitch_q, yaw_q;
  logic [31:0] last_ts;
  bit     have_ts;

  sample_t pending_samples[$];
  orient_t expected_orient[$];
  int  mismatches = 0;
  bit  calm = 1'b0;      // no idling in the last part
  int  hold_off = 0;     // long receiver stall, in cycles
  bit  stall_go = 1'b0;
  bit  stall_done = 1'b0;
  int  src_gap = 0, snk_gap = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_pi(longint v);
    longint r;
    r = v % ANG_2PI;
    if (r < -ANG_PI) r += ANG_2PI;
    if (r >= ANG_PI) r -= ANG_2PI;
    return r;
  endfunction

  function automatic longint tilt_atan2(longint yin, longint xin);
    longint x, y, z, t, xs, ys;
    x = xin * 16384;
    y = yin * 16384;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -ANG_HALF_PI;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_ROM[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_ROM[i];
      end
    end
    return z;
  endfunction

  function automatic longint mix_angle(longint ang, longint acc);
    return wrap_pi(asr(gyro_w * ang + accel_w * acc + 32768, 16));
  endfunction

  function automatic orient_t predict_orientation(sample_t s);
    logic [31:0] dt;
    longint ix, iy, iz, ay, ax, az;
    orient_t o;
    if (!have_ts) begin
      last_ts = s.timestamp;
      have_ts = 1'b1;
    end
    dt = s.timestamp - last_ts;
    last_ts = s.timestamp;
    ix = asr(longint'(s.rate_x) * longint'({32'd0, dt}) + 128, 8);
    iy = asr(longint'(s.rate_y) * longint'({32'd0, dt}) + 128, 8);
    iz = asr(longint'(s.rate_z) * longint'({32'd0, dt}) + 128, 8);
    ax = longint'(s.accel_x);
    ay = longint'(s.accel_y);
    az = longint'(s.accel_z);
    if (az < 0) begin
      iy = -iy; iz = -iz; ay = -ay;
    end
    roll_q  = wrap_pi(roll_q + ix);
    pitch_q = wrap_pi(pitch_q + iy);
    yaw_q   = wrap_pi(yaw_q + iz);
    if (blend_on && az != 0) begin
      roll_q  = mix_angle(roll_q, tilt_atan2(ay, az));
      pitch_q = mix_angle(pitch_q, tilt_atan2(ax, az));
    end
    o.roll = roll_q[ANG_W-1:0];
    o.pitch = pitch_q[ANG_W-1:0];
    o.yaw = yaw_q[ANG_W-1:0];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_orient.push_back(predict_orientation(pending_samples.pop_front()));
      end
      if (in_if.valid && !in_if.ready) begin
        // keep offering the same beat
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(1, 10) - 1;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > (in_if.valid && in_if.ready ? 0 : 0) &&
                   pending_samples.size() > 0) begin
        in_if.valid     <= 1'b1;
        in_if.timestamp <= pending_samples[0].timestamp;
        in_if.rate_x    <= pending_samples[0].rate_x;
        in_if.rate_y    <= pending_samples[0].rate_y;
        in_if.rate_z    <= pending_samples[0].rate_z;
        in_if.accel_x   <= pending_samples[0].accel_x;
        in_if.accel_y   <= pending_samples[0].accel_y;
        in_if.accel_z   <= pending_samples[0].accel_z;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted down once started
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (stall_go && !stall_done) begin
      hold_off   <= 3000;
      stall_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // receiver ready and result check
  always @(posedge clk) begin
    orient_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_orient.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected orientation beat %h %h %h",
            out_if.roll_out, out_if.pitch_out, out_if.yaw_out);
        end else begin
          want = expected_orient.pop_front();
          if (want.roll !== out_if.roll_out || want.pitch !== out_if.pitch_out ||
              want.yaw !== out_if.yaw_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("orientation mismatch: exp r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                want.roll, want.pitch, want.yaw,
                out_if.roll_out, out_if.pitch_out, out_if.yaw_out);
          end
        end
      end
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_gap <= $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.timestamp = '0;
    in_if.rate_x = '0; in_if.rate_y = '0; in_if.rate_z = '0;
    in_if.accel_x = '0; in_if.accel_y = '0; in_if.accel_z = '0;
    out_if.ready = 1'b0;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_GYRO_W:  gyro_w = longint'(val[WGT_W-1:0]);
      REG_ACCEL_W: accel_w = longint'(val[WGT_W-1:0]);
      REG_BLEND:   blend_on = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_orient.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(ref logic [31:0] ts, input bit tame);
    sample_t s;
    ts += tame ? $urandom_range(1, 5000) : $urandom;
    s.timestamp = ts;
    s.rate_x = tame ? RATE_W'($urandom_range(0, 1 << 20) - (1 << 19)) : RATE_W'($urandom);
    s.rate_y = tame ? RATE_W'($urandom_range(0, 1 << 20) - (1 << 19)) : RATE_W'($urandom);
    s.rate_z = RATE_W'($urandom);
    s.accel_x = ACCEL_W'($urandom);
    s.accel_y = ACCEL_W'($urandom);
    case ($urandom_range(0, 9))
      0: s.accel_z = '0;
      1: s.accel_z = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      default: s.accel_z = ACCEL_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic add_sample(logic [31:0] ts, int rx, int ry, int rz,
                            int ax, int ay, int az);
    sample_t s;
    s = '{ts, RATE_W'(rx), RATE_W'(ry), RATE_W'(rz),
          ACCEL_W'(ax), ACCEL_W'(ay), ACCEL_W'(az)};
    pending_samples.push_back(s);
  endtask

  initial begin
    logic [31:0] ts;
    gyro_w = longint'(GYRO_W_RST); accel_w = longint'(ACCEL_W_RST); blend_on = 1'b1;
    roll_q = 0; pitch_q = 0; yaw_q = 0; last_ts = '0; have_ts = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first sample, extremes, zero and negative z, wrap of timestamp
    add_sample(32'hffff_fff0, 8388607, -8388608, 100, 0, 0, 1000);
    add_sample(32'h0000_0010, 8388607, -8388608, -8388608, 100, -32768, -100);
    add_sample(32'h0000_1000, 1000, 2000, 3000, 500, 500, 0);
    add_sample(32'hffff_ffff, -8388608, 8388607, 8388607, -32768, 32767, -32768);
    add_sample(32'h7fff_ffff, 8388607, 8388607, 8388607, 32767, -32768, 32767);
    add_sample(32'h8000_0000, 0, 0, 0, 0, 0, -1);
    add_sample(32'h8000_0001, 0, 0, 0, 0, 0, -32768);  // atan2 at pi
    add_sample(32'h8000_0002, -1, -1, -1, -1, -1, -1);
    add_sample(32'h8000_0003, 1, 1, 1, 1, 1, 1);
    add_sample(32'h8000_0004, 0, 0, 0, -32768, -32768, 32767);
    wait_drained();

    // weights summing above one, then integration only
    reg_write(REG_GYRO_W, 65536);
    reg_write(REG_ACCEL_W, 65536);
    add_sample(32'h9000_0000, 12345, -54321, 777, 30000, -30000, 20000);
    add_sample(32'hc000_0000, -8388608, 8388607, 1, -20000, 20000, -20000);
    wait_drained();
    reg_write(REG_BLEND, 0);
    reg_write(REG_GYRO_W, 0);
    add_sample(32'h0000_0000, 8388607, 8388607, 8388607, 1, 1, -5);
    add_sample(32'h4000_0000, 8388607, -8388608, 8388607, 1, 1, 5);
    wait_drained();

    // random phases over several settings, including the extremes
    ts = 32'h1000;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin reg_write(REG_GYRO_W, GYRO_W_RST); reg_write(REG_ACCEL_W, ACCEL_W_RST);
                 reg_write(REG_BLEND, 1); end
        1: begin reg_write(REG_GYRO_W, 0); reg_write(REG_ACCEL_W, 65536); end
        2: reg_write(REG_BLEND, 0);
        3: begin reg_write(REG_BLEND, 1); reg_write(REG_GYRO_W, 131071);
                 reg_write(REG_ACCEL_W, 131071); end
        4: begin reg_write(REG_GYRO_W, $urandom_range(0, 65536));
                 reg_write(REG_ACCEL_W, $urandom_range(0, 65536)); end
        5: begin reg_write(REG_GYRO_W, 65536); reg_write(REG_ACCEL_W, 0); end
        default: begin reg_write(REG_GYRO_W, GYRO_W_RST);
                       reg_write(REG_ACCEL_W, ACCEL_W_RST); end
      endcase
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < 100; k++)
        pending_samples.push_back(rand_sample(ts, $urandom_range(0, 3) != 0));
      if (ph == 2) begin
        // long receiver stall while samples keep coming
        stall_go = 1'b1;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_orient.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #(20ns * 900000);
    $display("tb: done, errors");
    $finish;
  end
endmodule

// ----- imu_complementary_orientation.f -----
hw/rtl/imuco_pkg.sv
hw/rtl/imuco_in_if.sv
hw/rtl/imuco_out_if.sv
hw/rtl/imu_complementary_orientation.sv
test/tb.sv
